// File: sv/ffha_pkg.sv
// Shared types and constants of the first-fit heap allocator.
// Holds the transaction payload structs, the code enums and the table entry layout.
// Depends on nothing; the top level refers to it by scoped names and the testbench imports it.
package ffha_pkg;

  // Table depth and the width of the address space the heap may span.
  localparam int unsigned MAX_BLOCKS = 256;
  localparam int unsigned ADDR_BITS  = 20;

  // Fixed field widths of the transactions.
  localparam int unsigned ADDR_W = 20;
  localparam int unsigned SIZE_W = 21;
  localparam int unsigned HDR_W  = 7;

  localparam int unsigned IDX_W = $clog2(MAX_BLOCKS);
  localparam int unsigned CNT_W = $clog2(MAX_BLOCKS + 1);

  // The heap limit in force is the smaller of the register and the address space.
  localparam logic [SIZE_W:0] LIMIT_CAP =
    (ADDR_BITS >= SIZE_W) ? {1'b1, {SIZE_W{1'b0}}} : (SIZE_W + 1)'(64'd1 << ADDR_BITS);

  // Mask applied to returned addresses.
  localparam logic [ADDR_W-1:0] ADDR_MASK =
    (ADDR_BITS >= ADDR_W) ? {ADDR_W{1'b1}} : ADDR_W'((64'd1 << ADDR_BITS) - 64'd1);

  localparam logic [HDR_W-1:0] HDR_MIN   = 7'd8;
  localparam logic [HDR_W-1:0] HDR_MAX   = 7'd64;
  localparam logic [HDR_W-1:0] HDR_RESET = 7'd24;
  localparam logic [SIZE_W-1:0] LIMIT_RESET = 21'h100000;
  localparam logic [SIZE_W-1:0] SIZE_MAX    = {SIZE_W{1'b1}};

  typedef enum logic [1:0] {
    ACT_MALLOC  = 2'd0,
    ACT_FREE    = 2'd1,
    ACT_REALLOC = 2'd2,
    ACT_CALLOC  = 2'd3
  } action_e;

  typedef enum logic [2:0] {
    ST_OK        = 3'd0,
    ST_ZERO      = 3'd1,
    ST_EXHAUSTED = 3'd2,
    ST_FULL      = 3'd3,
    ST_BADADDR   = 3'd4
  } status_e;

  typedef enum logic [0:0] {
    CFG_HEAP_LIMIT = 1'b0,
    CFG_HEADER     = 1'b1
  } cfg_idx_e;

  typedef struct packed {
    action_e           action;
    logic [SIZE_W-1:0] req_size;
    logic [ADDR_W-1:0] user_address;
    logic [SIZE_W-1:0] elem_count;
    logic [SIZE_W-1:0] elem_bytes;
  } req_t;

  typedef struct packed {
    status_e           status;
    logic [ADDR_W-1:0] result_address;
    logic [ADDR_W-1:0] copy_source;
    logic [SIZE_W-1:0] copy_length;
    logic [SIZE_W-1:0] clear_length;
  } rsp_t;

  // One row of the block table.
  typedef struct packed {
    logic [ADDR_W-1:0] start;
    logic [SIZE_W-1:0] size;
    logic              is_free;
  } entry_t;

  localparam int unsigned ENTRY_W = $bits(entry_t);

endpackage

// File: sv/ffha_ram.sv
// Generic simple dual-port RAM: one write port, one read port with registered data.
// Used for the block table of the heap allocator; no package dependency.
module ffha_ram #(
  parameter int unsigned WIDTH = 8,
  parameter int unsigned DEPTH = 256
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(DEPTH)-1:0] waddr_i,
  input  logic [WIDTH-1:0]         wdata_i,
  input  logic                     re_i,
  input  logic [$clog2(DEPTH)-1:0] raddr_i,
  output logic [WIDTH-1:0]         rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    if (re_i) begin
      rdata_q <= mem_q[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

// File: sv/first_fit_heap_allocator.sv
// Top level of the first-fit heap allocator: sequencer, table scans and result register.
// Depends on ffha_pkg for types and constants and on ffha_ram for the block table.
//
//   Channel  Direction  Handshake                  Payload
//   in       input      in_valid_i / in_ready_o    in_req_i   (ffha_pkg::req_t)
//   out      output     out_valid_o / out_ready_i  out_rsp_o  (ffha_pkg::rsp_t)
//   cfg      input      cfg_we_i (no wait)         cfg_idx_i, cfg_data_i
//
// One transaction is handled at a time. Each pass over the block table reads one entry
// per cycle from the table RAM until all live entries are read. Malloc makes one fit
// pass and free one find pass; calloc forms the product first, and a realloc that has to
// move makes a find pass and then a fit pass and frees its old block last. The single
// read port of the table RAM sets this pace.
// Reset clears the entry count and the heap top at once; the table needs no clearing,
// since only entries below the count are ever read. A result waits in the output
// register while the next request is accepted; only the final step stalls on out_ready_i.
module first_fit_heap_allocator (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  logic                 in_valid_i,
  output logic                 in_ready_o,
  input  ffha_pkg::req_t       in_req_i,
  output logic                 out_valid_o,
  input  logic                 out_ready_i,
  output ffha_pkg::rsp_t       out_rsp_o,
  input  logic                 cfg_we_i,
  input  ffha_pkg::cfg_idx_e   cfg_idx_i,
  input  logic [ffha_pkg::SIZE_W-1:0] cfg_data_i
);

  localparam int unsigned IDX_W  = ffha_pkg::IDX_W;
  localparam int unsigned CNT_W  = ffha_pkg::CNT_W;
  localparam int unsigned SIZE_W = ffha_pkg::SIZE_W;
  localparam int unsigned ADDR_W = ffha_pkg::ADDR_W;
  localparam int unsigned HDR_W  = ffha_pkg::HDR_W;

  // Sequencer states, one-hot.
  typedef enum logic [5:0] {
    S_IDLE   = 6'b000001,
    S_MUL    = 6'b000010,
    S_FIND   = 6'b000100,
    S_FIT    = 6'b001000,
    S_WR_OLD = 6'b010000,
    S_DONE   = 6'b100000
  } state_e;

  state_e state_q, state_d;

  // Configuration registers.
  logic [SIZE_W-1:0] heap_limit_q;
  logic [HDR_W-1:0]  header_q;

  // Architectural state held outside the table.
  logic [CNT_W-1:0]  count_q, count_d;
  logic [SIZE_W-1:0] heap_top_q, heap_top_d;

  // Request context.
  ffha_pkg::req_t    req_q, req_d;
  logic [2*SIZE_W-1:0] prod_q, prod_d;
  logic [SIZE_W-1:0] alloc_size_q, alloc_size_d;

  // Scan pipeline: the address being read and the entry whose data is back.
  logic [CNT_W-1:0]  scan_idx_q, scan_idx_d;
  logic              chk_vld_q, chk_vld_d;
  logic [IDX_W-1:0]  chk_idx_q, chk_idx_d;

  // The old block found by a realloc, freed once the new block is secured.
  logic [IDX_W-1:0]  old_idx_q, old_idx_d;
  logic [ADDR_W-1:0] old_start_q, old_start_d;
  logic [SIZE_W-1:0] old_size_q, old_size_d;

  // Result under construction and the output register.
  ffha_pkg::rsp_t    rsp_q, rsp_d;
  ffha_pkg::rsp_t    out_q, out_d;
  logic              out_valid_q, out_valid_d;

  // Table RAM ports.
  logic              ram_we, ram_re;
  logic [IDX_W-1:0]  ram_waddr;
  ffha_pkg::entry_t  ram_wdata, rd_entry;
  logic [ffha_pkg::ENTRY_W-1:0] ram_rdata;

  ffha_ram #(
    .WIDTH (ffha_pkg::ENTRY_W),
    .DEPTH (ffha_pkg::MAX_BLOCKS)
  ) u_table (
    .clk_i   (clk_i),
    .we_i    (ram_we),
    .waddr_i (ram_waddr),
    .wdata_i (ram_wdata),
    .re_i    (ram_re),
    .raddr_i (scan_idx_q[IDX_W-1:0]),
    .rdata_o (ram_rdata)
  );

  assign rd_entry = ffha_pkg::entry_t'(ram_rdata);

  // Header size saturated into its legal range.
  logic [HDR_W-1:0] hdr;
  always_comb begin
    priority if (header_q < ffha_pkg::HDR_MIN) begin
      hdr = ffha_pkg::HDR_MIN;
    end else if (header_q > ffha_pkg::HDR_MAX) begin
      hdr = ffha_pkg::HDR_MAX;
    end else begin
      hdr = header_q;
    end
  end

  // Heap bound in force and the growth check for an append.
  logic [SIZE_W:0]   limit_now;
  logic [SIZE_W+1:0] need_top;
  logic [SIZE_W-1:0] top_plus_h;
  logic [SIZE_W-1:0] start_plus_h;
  logic              exhausted, table_full;
  logic              find_hit, fit_hit, scan_end;

  assign limit_now = ({1'b0, heap_limit_q} < ffha_pkg::LIMIT_CAP) ?
                     {1'b0, heap_limit_q} : ffha_pkg::LIMIT_CAP;
  assign need_top  = {2'b00, heap_top_q} + (SIZE_W + 2)'(hdr) + {2'b00, alloc_size_q};
  assign exhausted = need_top > {1'b0, limit_now};
  assign table_full = count_q >= CNT_W'(ffha_pkg::MAX_BLOCKS);
  assign top_plus_h   = heap_top_q + SIZE_W'(hdr);
  assign start_plus_h = {1'b0, rd_entry.start} + SIZE_W'(hdr);

  // A read is issued while unread live entries remain; the pass ends with no data
  // pending and nothing left to read.
  assign ram_re   = ((state_q == S_FIND) || (state_q == S_FIT)) && (scan_idx_q < count_q);
  assign scan_end = !chk_vld_q && !ram_re;
  assign find_hit = chk_vld_q && !rd_entry.is_free &&
                    (start_plus_h == {1'b0, req_q.user_address});
  assign fit_hit  = chk_vld_q && rd_entry.is_free && (rd_entry.size >= alloc_size_q);

  always_comb begin
    logic fit_ok;
    fit_ok       = 1'b0;
    state_d      = state_q;
    count_d      = count_q;
    heap_top_d   = heap_top_q;
    req_d        = req_q;
    prod_d       = prod_q;
    alloc_size_d = alloc_size_q;
    scan_idx_d   = '0;
    chk_vld_d    = 1'b0;
    chk_idx_d    = chk_idx_q;
    old_idx_d    = old_idx_q;
    old_start_d  = old_start_q;
    old_size_d   = old_size_q;
    rsp_d        = rsp_q;
    out_d        = out_q;
    out_valid_d  = out_valid_q && !out_ready_i;
    ram_we       = 1'b0;
    ram_waddr    = chk_idx_q;
    ram_wdata    = rd_entry;

    if (ram_re) begin
      scan_idx_d = scan_idx_q + CNT_W'(1);
      chk_vld_d  = 1'b1;
      chk_idx_d  = scan_idx_q[IDX_W-1:0];
    end else begin
      scan_idx_d = scan_idx_q;
    end

    unique case (state_q)
      S_IDLE: begin
        scan_idx_d = '0;
        chk_vld_d  = 1'b0;
        if (in_valid_i) begin
          req_d        = in_req_i;
          prod_d       = in_req_i.elem_count * in_req_i.elem_bytes;
          alloc_size_d = in_req_i.req_size;
          rsp_d        = '0;
          unique case (in_req_i.action)
            ffha_pkg::ACT_MALLOC: begin
              if (in_req_i.req_size == '0) begin
                rsp_d.status = ffha_pkg::ST_ZERO;
                state_d      = S_DONE;
              end else begin
                state_d = S_FIT;
              end
            end
            ffha_pkg::ACT_FREE: begin
              state_d = (in_req_i.user_address == '0) ? S_DONE : S_FIND;
            end
            ffha_pkg::ACT_REALLOC: begin
              if (in_req_i.user_address != '0) begin
                state_d = S_FIND;
              end else if (in_req_i.req_size == '0) begin
                rsp_d.status = ffha_pkg::ST_ZERO;
                state_d      = S_DONE;
              end else begin
                state_d = S_FIT;
              end
            end
            ffha_pkg::ACT_CALLOC: begin
              state_d = S_MUL;
            end
            default: begin
              state_d = S_DONE;
            end
          endcase
        end
      end

      S_MUL: begin
        scan_idx_d = '0;
        chk_vld_d  = 1'b0;
        priority if (prod_q == '0) begin
          rsp_d.status = ffha_pkg::ST_ZERO;
          state_d      = S_DONE;
        end else if (prod_q > (2 * SIZE_W)'(ffha_pkg::SIZE_MAX)) begin
          rsp_d.status = ffha_pkg::ST_EXHAUSTED;
          state_d      = S_DONE;
        end else begin
          alloc_size_d = prod_q[SIZE_W-1:0];
          state_d      = S_FIT;
        end
      end

      S_FIND: begin
        if (find_hit) begin
          scan_idx_d  = '0;
          chk_vld_d   = 1'b0;
          old_idx_d   = chk_idx_q;
          old_start_d = rd_entry.start;
          old_size_d  = rd_entry.size;
          if (req_q.action == ffha_pkg::ACT_FREE) begin
            ram_we            = 1'b1;
            ram_wdata.is_free = 1'b1;
            state_d           = S_DONE;
          end else if (rd_entry.size >= req_q.req_size) begin
            rsp_d.result_address = req_q.user_address;
            state_d              = S_DONE;
          end else begin
            state_d = S_FIT;
          end
        end else if (scan_end) begin
          rsp_d.status = ffha_pkg::ST_BADADDR;
          state_d      = S_DONE;
        end
      end

      S_FIT: begin
        if (fit_hit) begin
          // Reuse the whole free block.
          ram_we               = 1'b1;
          ram_wdata.is_free    = 1'b0;
          rsp_d.result_address = start_plus_h[ADDR_W-1:0] & ffha_pkg::ADDR_MASK;
          fit_ok               = 1'b1;
        end else if (scan_end) begin
          priority if (exhausted) begin
            rsp_d.status = ffha_pkg::ST_EXHAUSTED;
            state_d      = S_DONE;
          end else if (table_full) begin
            rsp_d.status = ffha_pkg::ST_FULL;
            state_d      = S_DONE;
          end else begin
            // Append a new block at the heap top.
            ram_we               = 1'b1;
            ram_waddr            = count_q[IDX_W-1:0];
            ram_wdata.start      = heap_top_q[ADDR_W-1:0];
            ram_wdata.size       = alloc_size_q;
            ram_wdata.is_free    = 1'b0;
            count_d              = count_q + CNT_W'(1);
            heap_top_d           = need_top[SIZE_W-1:0];
            rsp_d.result_address = top_plus_h[ADDR_W-1:0] & ffha_pkg::ADDR_MASK;
            fit_ok               = 1'b1;
          end
        end
        if (fit_ok) begin
          scan_idx_d = '0;
          chk_vld_d  = 1'b0;
          if (req_q.action == ffha_pkg::ACT_REALLOC && req_q.user_address != '0) begin
            state_d = S_WR_OLD;
          end else begin
            if (req_q.action == ffha_pkg::ACT_CALLOC) begin
              rsp_d.clear_length = alloc_size_q;
            end
            state_d = S_DONE;
          end
        end
      end

      S_WR_OLD: begin
        // The moved block gives up its old place.
        ram_we               = 1'b1;
        ram_waddr            = old_idx_q;
        ram_wdata.start      = old_start_q;
        ram_wdata.size       = old_size_q;
        ram_wdata.is_free    = 1'b1;
        rsp_d.copy_source    = req_q.user_address;
        rsp_d.copy_length    = old_size_q;
        state_d              = S_DONE;
      end

      S_DONE: begin
        if (!out_valid_q || out_ready_i) begin
          out_d       = rsp_q;
          out_valid_d = 1'b1;
          state_d     = S_IDLE;
        end
      end

      default: begin
        state_d = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q      <= S_IDLE;
      count_q      <= '0;
      heap_top_q   <= '0;
      scan_idx_q   <= '0;
      chk_vld_q    <= 1'b0;
      out_valid_q  <= 1'b0;
      heap_limit_q <= ffha_pkg::LIMIT_RESET;
      header_q     <= ffha_pkg::HDR_RESET;
    end else begin
      state_q     <= state_d;
      count_q     <= count_d;
      heap_top_q  <= heap_top_d;
      scan_idx_q  <= scan_idx_d;
      chk_vld_q   <= chk_vld_d;
      out_valid_q <= out_valid_d;
      if (cfg_we_i) begin
        unique case (cfg_idx_i)
          ffha_pkg::CFG_HEAP_LIMIT: heap_limit_q <= cfg_data_i;
          ffha_pkg::CFG_HEADER:     header_q     <= cfg_data_i[HDR_W-1:0];
          default:                  header_q     <= header_q;
        endcase
      end
    end
  end

  // Payload and context registers carry no reset.
  always_ff @(posedge clk_i) begin
    req_q        <= req_d;
    prod_q       <= prod_d;
    alloc_size_q <= alloc_size_d;
    chk_idx_q    <= chk_idx_d;
    old_idx_q    <= old_idx_d;
    old_start_q  <= old_start_d;
    old_size_q   <= old_size_d;
    rsp_q        <= rsp_d;
    out_q        <= out_d;
  end

  assign in_ready_o  = (state_q == S_IDLE);
  assign out_valid_o = out_valid_q;
  assign out_rsp_o   = out_q;

  // The live entry count can never pass the table depth.
  a_count_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    count_q <= CNT_W'(ffha_pkg::MAX_BLOCKS))
    else $error("entry count beyond table depth");

  // Data coming back from a scan read always belongs to a live entry.
  a_chk_live: assert property (@(posedge clk_i) disable iff (!rst_ni)
    chk_vld_q |-> ({1'b0, chk_idx_q} < count_q))
    else $error("scan checks an entry beyond the count");

  // An accepted transaction occupies the sequencer in the following cycle.
  a_busy_after_accept: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (in_valid_i && in_ready_o) |=> !in_ready_o)
    else $error("request accepted while busy");

  // The table is only written by a scan hit, an append at the scan end and the old-block release.
  a_write_states: assert property (@(posedge clk_i) disable iff (!rst_ni)
    ram_we |-> (state_q == S_FIND || state_q == S_FIT || state_q == S_WR_OLD))
    else $error("table write outside a modify step");

endmodule

// File: tb/heap_result_checker.sv
// Result checker for the first-fit heap allocator: watches the request, result and register
// channels, keeps its own copy of the block table and compares every result.
// Depends on ffha_pkg for the transaction structs, the codes and the table dimensions.
`timescale 1ns / 1ps

module heap_result_checker (
  input  logic                        clk_i,
  input  logic                        rst_ni,
  input  logic                        in_valid_i,
  input  logic                        in_ready_i,
  input  ffha_pkg::req_t              in_req_i,
  input  logic                        out_valid_i,
  input  logic                        out_ready_i,
  input  ffha_pkg::rsp_t              out_rsp_i,
  input  logic                        cfg_we_i,
  input  ffha_pkg::cfg_idx_e          cfg_idx_i,
  input  logic [ffha_pkg::SIZE_W-1:0] cfg_data_i,
  output int unsigned                 fail_count_o,
  output int unsigned                 rsp_count_o
);
  import ffha_pkg::*;

  // Shadow copy of the allocator state.
  logic [ADDR_W-1:0] blk_start [MAX_BLOCKS];
  logic [SIZE_W-1:0] blk_size  [MAX_BLOCKS];
  logic              blk_free  [MAX_BLOCKS];
  int unsigned       blk_count;
  longint unsigned   brk_top;
  logic [SIZE_W-1:0] limit_reg;
  logic [HDR_W-1:0]  hdr_reg;

  rsp_t              awaited_rsp_q [$];
  int unsigned       mismatches = 0;
  int unsigned       open_count = 0;

  assign fail_count_o = mismatches + open_count;

  function automatic longint unsigned hdr_in_force();
    if (hdr_reg < HDR_MIN) return HDR_MIN;
    if (hdr_reg > HDR_MAX) return HDR_MAX;
    return hdr_reg;
  endfunction

  function automatic longint unsigned limit_in_force();
    longint unsigned cap;
    cap = 64'd1 << ADDR_BITS;
    return (limit_reg < cap) ? limit_reg : cap;
  endfunction

  // First fit over free blocks, else a fresh block at the heap top.
  function automatic status_e claim_block(input longint unsigned size,
                                          output longint unsigned addr);
    longint unsigned h;
    h    = hdr_in_force();
    addr = 0;
    if (size == 0) return ST_ZERO;
    for (int unsigned i = 0; i < blk_count; i++) begin
      if (blk_free[i] && blk_size[i] >= size) begin
        blk_free[i] = 1'b0;
        addr        = 64'(blk_start[i]) + h;
        return ST_OK;
      end
    end
    if (brk_top + h + size > limit_in_force()) return ST_EXHAUSTED;
    if (blk_count >= MAX_BLOCKS) return ST_FULL;
    blk_start[blk_count] = ADDR_W'(brk_top);
    blk_size[blk_count]  = SIZE_W'(size);
    blk_free[blk_count]  = 1'b0;
    blk_count++;
    addr    = brk_top + h;
    brk_top = brk_top + h + size;
    return ST_OK;
  endfunction

  // Addresses are matched against the header size in force now, not the one at allocation.
  function automatic int live_index(input logic [ADDR_W-1:0] addr);
    longint unsigned h;
    h = hdr_in_force();
    for (int unsigned i = 0; i < blk_count; i++) begin
      if (!blk_free[i] && 64'(blk_start[i]) + h == 64'(addr)) return int'(i);
    end
    return -1;
  endfunction

  function automatic rsp_t alloc_outcome(input req_t r);
    rsp_t            o;
    longint unsigned addr;
    longint unsigned prod;
    int              k;
    o      = '0;
    addr   = 0;
    case (r.action)
      ACT_MALLOC: begin
        o.status = claim_block(r.req_size, addr);
      end
      ACT_FREE: begin
        if (r.user_address != '0) begin
          k = live_index(r.user_address);
          if (k < 0) o.status = ST_BADADDR;
          else blk_free[k] = 1'b1;
        end
      end
      ACT_REALLOC: begin
        if (r.user_address == '0) begin
          o.status = claim_block(r.req_size, addr);
        end else begin
          k = live_index(r.user_address);
          if (k < 0) begin
            o.status = ST_BADADDR;
          end else if (blk_size[k] >= r.req_size) begin
            addr = r.user_address;
          end else begin
            // The old block is only released once the new one is secured.
            o.status = claim_block(r.req_size, addr);
            if (o.status == ST_OK) begin
              blk_free[k]   = 1'b1;
              o.copy_source = r.user_address;
              o.copy_length = blk_size[k];
            end
          end
        end
      end
      ACT_CALLOC: begin
        prod = 64'(r.elem_count) * 64'(r.elem_bytes);
        if (prod == 0) begin
          o.status = ST_ZERO;
        end else if (prod > 64'(SIZE_MAX)) begin
          o.status = ST_EXHAUSTED;
        end else begin
          o.status = claim_block(prod, addr);
          if (o.status == ST_OK) o.clear_length = SIZE_W'(prod);
        end
      end
    endcase
    o.result_address = ADDR_W'(addr) & ADDR_MASK;
    return o;
  endfunction

  task automatic compare_rsp(input rsp_t got, input rsp_t want);
    if (got.status !== want.status) begin
      $error("status field: expected %0d, got %0d", want.status, got.status);
      mismatches++;
    end
    if (got.result_address !== want.result_address) begin
      $error("result_address: expected 0x%0h, got 0x%0h", want.result_address,
             got.result_address);
      mismatches++;
    end
    if (got.copy_source !== want.copy_source) begin
      $error("copy_source: expected 0x%0h, got 0x%0h", want.copy_source, got.copy_source);
      mismatches++;
    end
    if (got.copy_length !== want.copy_length) begin
      $error("copy_length: expected %0d, got %0d", want.copy_length, got.copy_length);
      mismatches++;
    end
    if (got.clear_length !== want.clear_length) begin
      $error("clear_length: expected %0d, got %0d", want.clear_length, got.clear_length);
      mismatches++;
    end
  endtask

  // A result leaving at an edge always belongs to an earlier request, so it is matched
  // before the request taken at the same edge is predicted.
  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      blk_count = 0;
      brk_top   = 0;
      limit_reg = LIMIT_RESET;
      hdr_reg   = HDR_RESET;
      awaited_rsp_q.delete();
      open_count = 0;
      rsp_count_o <= 0;
    end else begin
      if (out_valid_i && out_ready_i) begin
        rsp_count_o <= rsp_count_o + 1;
        if (awaited_rsp_q.size() == 0) begin
          $error("result transaction arrived with no request outstanding");
          mismatches++;
        end else begin
          compare_rsp(out_rsp_i, awaited_rsp_q.pop_front());
        end
      end
      if (cfg_we_i) begin
        case (cfg_idx_i)
          CFG_HEAP_LIMIT: limit_reg = cfg_data_i;
          CFG_HEADER:     hdr_reg   = cfg_data_i[HDR_W-1:0];
        endcase
      end
      if (in_valid_i && in_ready_i) awaited_rsp_q.push_back(alloc_outcome(in_req_i));
      open_count = awaited_rsp_q.size();
    end
  end

endmodule

// File: tb/tb.sv
// Top of the first-fit heap allocator testbench: clock, reset, request stimulus, result
// back-pressure and register writes, with the verdict at the end.
// Depends on ffha_pkg, on first_fit_heap_allocator and on heap_result_checker.
`timescale 1ns / 1ps

module tb;
  import ffha_pkg::*;

  // Generous bound on the whole run, in clock cycles.
  localparam int unsigned RUN_LIMIT   = 4000000;
  // Length of the long receiver hold-off that fills the allocator and stalls its input.
  localparam int unsigned HOLD_CYCLES = 2000;
  // Slack after the last result, roughly one worst-case realloc.
  localparam int unsigned TAIL_CYCLES = 600;

  logic              clk_i       = 1'b0;
  logic              rst_ni      = 1'b0;
  logic              in_valid_i  = 1'b0;
  logic              in_ready_o;
  req_t              in_req_i    = '0;
  logic              out_valid_o;
  logic              out_ready_i = 1'b0;
  rsp_t              out_rsp_o;
  logic              cfg_we_i    = 1'b0;
  cfg_idx_e          cfg_idx_i   = CFG_HEAP_LIMIT;
  logic [SIZE_W-1:0] cfg_data_i  = '0;

  int unsigned fail_count;
  int unsigned rsp_seen;
  int unsigned req_sent    = 0;
  int unsigned cycle_count = 0;

  // Idle percentages of the two sides, changed from phase to phase.
  int unsigned tx_idle_pct = 0;
  int unsigned rx_idle_pct = 0;

  // The stimulus asks for a hold-off by bumping hold_asked; the receiver counts it out.
  int unsigned hold_asked = 0;
  int unsigned hold_done  = 0;
  int unsigned hold_left  = 0;

  // Addresses recently handed out, so that frees and reallocs mostly hit real blocks.
  logic [ADDR_W-1:0] addr_pool [$];

  always begin
    #4 clk_i = 1'b1;
    #4 clk_i = 1'b0;
  end

  first_fit_heap_allocator dut (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid_i),
    .in_ready_o  (in_ready_o),
    .in_req_i    (in_req_i),
    .out_valid_o (out_valid_o),
    .out_ready_i (out_ready_i),
    .out_rsp_o   (out_rsp_o),
    .cfg_we_i    (cfg_we_i),
    .cfg_idx_i   (cfg_idx_i),
    .cfg_data_i  (cfg_data_i)
  );

  heap_result_checker heap_check (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .in_valid_i   (in_valid_i),
    .in_ready_i   (in_ready_o),
    .in_req_i     (in_req_i),
    .out_valid_i  (out_valid_o),
    .out_ready_i  (out_ready_i),
    .out_rsp_i    (out_rsp_o),
    .cfg_we_i     (cfg_we_i),
    .cfg_idx_i    (cfg_idx_i),
    .cfg_data_i   (cfg_data_i),
    .fail_count_o (fail_count),
    .rsp_count_o  (rsp_seen)
  );

  // Watchdog: a hung handshake ends the run as a failure.
  always @(posedge clk_i) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count == RUN_LIMIT) begin
      $display("status: fail");
      $finish;
    end
  end

  // Receiver side. Outside a hold-off it drops ready at random in rx_idle_pct cycles of a
  // hundred; during a hold-off it keeps ready low for the full count whatever the sender does.
  always @(posedge clk_i) begin
    if (hold_left != 0) begin
      out_ready_i <= 1'b0;
      hold_left   <= hold_left - 1;
    end else if (hold_asked != hold_done) begin
      out_ready_i <= 1'b0;
      hold_done   <= hold_asked;
      hold_left   <= HOLD_CYCLES;
    end else begin
      out_ready_i <= ($urandom_range(99) >= rx_idle_pct);
    end
  end

  // Collect the addresses that come back, keeping only the most recent ones.
  always @(posedge clk_i) begin
    if (rst_ni && out_valid_o && out_ready_i && out_rsp_o.result_address != '0) begin
      addr_pool.push_back(out_rsp_o.result_address);
      if (addr_pool.size() > 64) void'(addr_pool.pop_front());
    end
  end

  function automatic req_t make_req(input action_e act, input logic [SIZE_W-1:0] size,
                                    input logic [ADDR_W-1:0] addr,
                                    input logic [SIZE_W-1:0] cnt,
                                    input logic [SIZE_W-1:0] each);
    req_t r;
    r.action       = act;
    r.req_size     = size;
    r.user_address = addr;
    r.elem_count   = cnt;
    r.elem_bytes   = each;
    return r;
  endfunction

  // Mostly modest sizes; a few zero and a few so large that they can never fit.
  function automatic logic [SIZE_W-1:0] draw_size();
    int unsigned roll;
    roll = $urandom_range(99);
    if (roll < 4) return '0;
    if (roll < 7) return SIZE_W'($urandom_range(21'h1FFFFF, 21'h0FFFC0));
    if (roll < 27) return SIZE_W'($urandom_range(4096, 257));
    return SIZE_W'($urandom_range(256, 1));
  endfunction

  // Calloc factors: small on the whole, with zeros and full-width values mixed in.
  function automatic logic [SIZE_W-1:0] draw_factor();
    int unsigned roll;
    roll = $urandom_range(99);
    if (roll < 6) return '0;
    if (roll < 12) return SIZE_W'($urandom_range(21'h1FFFFF));
    return SIZE_W'($urandom_range(64, 1));
  endfunction

  // Usually an address that was handed out, otherwise null or an arbitrary value.
  function automatic logic [ADDR_W-1:0] draw_addr();
    int unsigned roll;
    roll = $urandom_range(99);
    if (roll < 10 || addr_pool.size() == 0) return ADDR_W'($urandom_range(20'hFFFFF));
    if (roll < 20) return '0;
    return addr_pool[$urandom_range(addr_pool.size() - 1)];
  endfunction

  // Every field is filled, used or not, so that unused bits toggle as well.
  function automatic req_t draw_request();
    int unsigned roll;
    action_e     act;
    roll = $urandom_range(99);
    if (roll < 40)      act = ACT_MALLOC;
    else if (roll < 60) act = ACT_FREE;
    else if (roll < 85) act = ACT_REALLOC;
    else                act = ACT_CALLOC;
    return make_req(act, draw_size(), draw_addr(), draw_factor(), draw_factor());
  endfunction

  // Offers one request and holds it until the allocator takes it. Valid is only lowered
  // when an idle gap follows, so that back-to-back transactions keep it high throughout.
  task automatic offer(input req_t r);
    int unsigned gap;
    in_valid_i <= 1'b1;
    in_req_i   <= r;
    do @(posedge clk_i); while (!in_ready_o);
    req_sent++;
    gap = 0;
    while ($urandom_range(99) < tx_idle_pct) gap++;
    if (gap != 0) begin
      in_valid_i <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
  endtask

  // Waits until every request has produced its result, plus a little slack.
  task automatic settle();
    in_valid_i <= 1'b0;
    while (rsp_seen < req_sent) @(posedge clk_i);
    repeat (16) @(posedge clk_i);
  endtask

  task automatic write_reg(input cfg_idx_e idx, input logic [SIZE_W-1:0] val);
    cfg_we_i   <= 1'b1;
    cfg_idx_i  <= idx;
    cfg_data_i <= val;
    @(posedge clk_i);
    cfg_we_i <= 1'b0;
    @(posedge clk_i);
  endtask

  task automatic run_phase(input int unsigned n, input int unsigned tx_pct,
                           input int unsigned rx_pct, input int hold_at);
    tx_idle_pct = tx_pct;
    rx_idle_pct = rx_pct;
    for (int i = 0; i < int'(n); i++) begin
      if (i == hold_at) hold_asked++;
      offer(draw_request());
    end
  endtask

  initial begin
    repeat (9) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // Directed sequence with the reset settings (header 24, limit 1 MiB). The addresses
    // below follow from an empty heap: the first block sits at 0, so its user address is 24.
    offer(make_req(ACT_MALLOC, '0, '0, '0, '0));                   // zero size
    offer(make_req(ACT_MALLOC, 21'd1, '0, '0, '0));                // block at 24
    offer(make_req(ACT_MALLOC, 21'h100000, '0, '0, '0));           // beyond the limit
    offer(make_req(ACT_MALLOC, 21'h1FFFFF, '0, '0, '0));           // largest request
    offer(make_req(ACT_CALLOC, '0, '0, '0, 21'h1FFFFF));           // zero product
    offer(make_req(ACT_CALLOC, '0, '0, 21'h1FFFFF, '0));           // zero product
    offer(make_req(ACT_CALLOC, '0, '0, 21'h1FFFFF, 21'h1FFFFF));   // product overflows
    offer(make_req(ACT_CALLOC, '0, '0, 21'd3, 21'd7));             // 21 bytes, address 49
    offer(make_req(ACT_FREE, '0, '0, '0, '0));                     // free of null
    offer(make_req(ACT_FREE, '0, 20'hFFFFF, '0, '0));              // unknown address
    offer(make_req(ACT_FREE, '0, 20'd24, '0, '0));                 // release first block
    offer(make_req(ACT_FREE, '0, 20'd24, '0, '0));                 // double free
    offer(make_req(ACT_MALLOC, 21'd1, '0, '0, '0));                // reuses the block at 24
    offer(make_req(ACT_REALLOC, '0, 20'd24, '0, '0));              // shrink to zero, stays
    offer(make_req(ACT_REALLOC, 21'd1, 20'd24, '0, '0));           // same size, stays
    offer(make_req(ACT_REALLOC, 21'd100, 20'd24, '0, '0));         // moves, new address 94
    offer(make_req(ACT_REALLOC, 21'd5, 20'd24, '0, '0));           // old block now free
    offer(make_req(ACT_REALLOC, 21'd16, '0, '0, '0));              // realloc of null
    offer(make_req(ACT_REALLOC, '0, '0, '0, '0));                  // null with zero size
    offer(make_req(ACT_REALLOC, 21'h100000, 20'd94, '0, '0));      // cannot grow, stays live
    offer(make_req(ACT_FREE, '0, 20'd94, '0, '0));                 // still live, so released
    offer(make_req(ACT_CALLOC, '0, '0, 21'd1, 21'd100));           // reuses the block at 94
    offer(make_req(ACT_REALLOC, 21'd3, 20'd12345, '0, '0));        // unknown address
    offer(make_req(ACT_CALLOC, '0, '0, 21'h100000, 21'd1));        // fits no limit
    settle();

    // Smallest header while blocks from above are live, and a limit above the address space.
    write_reg(CFG_HEADER, 21'd8);
    write_reg(CFG_HEAP_LIMIT, 21'h1FFFFF);
    run_phase(420, 29, 85, -1);
    settle();

    // Header above the range saturates; a zero limit refuses every append at the heap top.
    write_reg(CFG_HEADER, 21'd127);
    write_reg(CFG_HEAP_LIMIT, 21'd0);
    run_phase(300, 85, 29, -1);
    settle();

    // Header below the range saturates; no idling, with one long receiver hold-off.
    write_reg(CFG_HEADER, 21'd3);
    write_reg(CFG_HEAP_LIMIT, 21'h0C0000);
    run_phase(230, 0, 0, 40);
    settle();

    write_reg(CFG_HEADER, 21'd64);
    write_reg(CFG_HEAP_LIMIT, 21'h100000);
    run_phase(200, 0, 0, -1);
    settle();
    repeat (TAIL_CYCLES) @(posedge clk_i);

    if (fail_count == 0) $display("status: pass");
    else $display("status: fail");
    $finish;
  end

endmodule
